/* design/mag_cal_pkg.sv */
// shared types, constants and the cordic angle table for the magnetometer correction unit
// no dependencies
package mag_cal_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;

  localparam int X_W = 27;  // cordic x/y width
  localparam int Z_W = 26;  // cordic angle width, 2^-16 degree

  localparam logic signed [Z_W-1:0] DEG_90  = Z_W'(90 * 65536);
  localparam logic signed [X_W-1:0] DEG_90H = X_W'(90 * 65536);
  localparam logic signed [X_W-1:0] DEG_360 = X_W'(360 * 65536);
  localparam logic [16:0] HD_FULL = 17'(360 * 64);

  // register indexes
  localparam logic [2:0] REG_OFFSET_X   = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z   = 3'd2;
  localparam logic [2:0] REG_MATRIX_0   = 3'd3;
  localparam logic [2:0] REG_MATRIX_1   = 3'd4;
  localparam logic [2:0] REG_MATRIX_2   = 3'd5;
  localparam logic [2:0] REG_CALIBRATED = 3'd6;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic               last_sample;
  } in_t;

  typedef struct packed {
    logic signed [23:0] corr_x;
    logic signed [23:0] corr_y;
    logic signed [23:0] corr_z;
    logic [14:0]        heading_deg;
    logic               valid_res;
    logic               last_out;
  } out_t;

  // corrected vector leaving the front end
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               cal;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
  } corr_t;

  // one cordic cell's worth of state
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic                 cal;
    logic                 zero;
    logic signed [23:0]   cx;
    logic signed [23:0]   cy;
    logic signed [23:0]   cz;
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } cordic_t;

  // round(atan(2^-i) * 180/pi * 2^16)
  function automatic logic [21:0] atan_entry(input int i);
    logic [21:0] v;
    case (i)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/mag_cal_front.sv */
// front end: scaling by 19661/256, hard-iron offset and soft-iron matrix, four register stages
// depends on mag_cal_pkg
module mag_cal_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  mag_cal_pkg::in_t    in_data,
  input  logic                cal,
  input  logic signed [23:0]  offset_x,
  input  logic signed [23:0]  offset_y,
  input  logic signed [23:0]  offset_z,
  input  logic [53:0]         row0,
  input  logic [53:0]         row1,
  input  logic [53:0]         row2,
  output mag_cal_pkg::corr_t  corr
);
  import mag_cal_pkg::*;

  localparam int SH = 24 - SAMPLE_BITS;
  localparam logic signed [15:0] SCALE_K = 16'sd19661;

  logic [3:0] vld_r;
  logic [2:0] last_r, cal_r;

  logic signed [23:0] s [3];
  logic signed [39:0] prod_r [3];
  logic signed [32:0] v_r [3];
  logic signed [50:0] p_r [9];
  logic signed [23:0] c_r [3];
  logic signed [17:0] coef [9];
  logic signed [52:0] acc [3];
  logic signed [52:0] rnd [3];
  logic signed [23:0] c_nxt [3];
  logic signed [23:0] offs [3];

  // sign extension from the configured sample width
  function automatic logic signed [23:0] sx(input logic [15:0] raw);
    logic [23:0] r;
    r = {8'b0, raw} << SH;
    return $signed(r) >>> SH;
  endfunction

  always_comb begin
    s[0] = sx(in_data.mag_x);
    s[1] = sx(in_data.mag_y);
    s[2] = sx(in_data.mag_z);
    offs[0] = offset_x;
    offs[1] = offset_y;
    offs[2] = offset_z;
    coef[0] = row0[17:0];  coef[1] = row0[35:18]; coef[2] = row0[53:36];
    coef[3] = row1[17:0];  coef[4] = row1[35:18]; coef[5] = row1[53:36];
    coef[6] = row2[17:0];  coef[7] = row2[35:18]; coef[8] = row2[53:36];
    for (int r = 0; r < 3; r++) begin
      acc[r] = 53'(p_r[3*r]) + 53'(p_r[3*r+1]) + 53'(p_r[3*r+2]) + 53'sd8192;
      rnd[r] = acc[r] >>> 14;
      if (rnd[r] > 53'sd8388607) begin
        c_nxt[r] = 24'sd8388607;
      end else if (rnd[r] < -53'sd8388608) begin
        c_nxt[r] = -24'sd8388608;
      end else begin
        c_nxt[r] = rnd[r][23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[1:0], in_data.last_sample};
    cal_r  <= {cal_r[1:0], cal};
    for (int a = 0; a < 3; a++) begin
      prod_r[a] <= s[a] * SCALE_K;
      v_r[a]    <= 33'((prod_r[a] + 40'sd128) >>> 8) + 33'(offs[a]);
      c_r[a]    <= c_nxt[a];
    end
    for (int k = 0; k < 9; k++) begin
      p_r[k] <= v_r[k % 3] * coef[k];
    end
  end

  // last and cal go through a separate flop for the final stage, in step with the data
  logic last_q, cal_q;
  always_ff @(posedge clk) begin
    last_q <= last_r[2];
    cal_q  <= cal_r[2];
  end

  assign corr.valid = vld_r[3];
  assign corr.last  = last_q;
  assign corr.cal   = cal_q;
  assign corr.cx    = c_r[0];
  assign corr.cy    = c_r[1];
  assign corr.cz    = c_r[2];

endmodule

/* design/mag_cal_cordic_cell.sv */
// one vectoring cordic rotation stage, registered, passes side data along
// depends on mag_cal_pkg
module mag_cal_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mag_cal_pkg::cordic_t d,
  output mag_cal_pkg::cordic_t q
);
  import mag_cal_pkg::*;

  localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_entry(STAGE));

  cordic_t cell_nxt, cell_r;
  logic vld_r;
  logic signed [X_W-1:0] xs, ys;

  always_comb begin
    cell_nxt = d;
    xs = d.x >>> STAGE;
    ys = d.y >>> STAGE;
    if (d.y >= 0) begin
      cell_nxt.x = d.x + ys;
      cell_nxt.y = d.y - xs;
      cell_nxt.z = d.z + ANG;
    end else begin
      cell_nxt.x = d.x - ys;
      cell_nxt.y = d.y + xs;
      cell_nxt.z = d.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  always_comb begin
    q = cell_r;
    q.valid = vld_r;
  end

endmodule

/* design/mag_calibrate_heading_unit.sv */
// top level: register file, front end, cordic cell chain and heading wrap
// depends on mag_cal_pkg, mag_cal_front, mag_cal_cordic_cell
//
// Fully pipelined magnetometer correction: one sample may be started every clock,
// busy is never raised, and each transaction yields exactly one result through
// four front-end stages for scale, offset, matrix products and rounding, one
// quadrant pre-rotation stage, one cell per cordic iteration (iterations capped at
// MAX_STAGES) and one output stage. The result is shown for a single cycle with
// out_valid high and the receiver cannot stall it, so it must take every result
// as it appears. Configuration is a 64-bit APB-style port, registers at 8-byte
// steps; write only while no transaction is in flight.
module mag_calibrate_heading_unit #(
  parameter int SAMPLE_BITS   = mag_cal_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STAGES = mag_cal_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mag_cal_pkg::in_t   in_data,
  output logic               out_valid,
  output mag_cal_pkg::out_t  out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import mag_cal_pkg::*;

  localparam int NST = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

  // configuration registers
  logic signed [23:0] offset_x_r, offset_y_r, offset_z_r;
  logic [53:0]        row0_r, row1_r, row2_r;
  logic               cal_r;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
      row0_r     <= '0;
      row1_r     <= '0;
      row2_r     <= '0;
      cal_r      <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OFFSET_X:   offset_x_r <= pwdata[23:0];
        REG_OFFSET_Y:   offset_y_r <= pwdata[23:0];
        REG_OFFSET_Z:   offset_z_r <= pwdata[23:0];
        REG_MATRIX_0:   row0_r     <= pwdata[53:0];
        REG_MATRIX_1:   row1_r     <= pwdata[53:0];
        REG_MATRIX_2:   row2_r     <= pwdata[53:0];
        REG_CALIBRATED: cal_r      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OFFSET_X:   prdata = {40'b0, offset_x_r};
      REG_OFFSET_Y:   prdata = {40'b0, offset_y_r};
      REG_OFFSET_Z:   prdata = {40'b0, offset_z_r};
      REG_MATRIX_0:   prdata = {10'b0, row0_r};
      REG_MATRIX_1:   prdata = {10'b0, row1_r};
      REG_MATRIX_2:   prdata = {10'b0, row2_r};
      REG_CALIBRATED: prdata = {63'b0, cal_r};
      default:        prdata = '0;
    endcase
  end

  // scale, offset and soft-iron matrix
  corr_t corr;

  mag_cal_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_data  (in_data),
    .cal      (cal_r),
    .offset_x (offset_x_r),
    .offset_y (offset_y_r),
    .offset_z (offset_z_r),
    .row0     (row0_r),
    .row1     (row1_r),
    .row2     (row2_r),
    .corr     (corr)
  );

  // quadrant pre-rotation on (x, -y) so the cordic stays in the right half plane
  cordic_t pre_nxt, pre_r;
  logic    pre_vld_r;
  logic signed [X_W-1:0] px, py;

  always_comb begin
    px = X_W'(corr.cx);
    py = -X_W'(corr.cy);
    pre_nxt.valid = corr.valid;
    pre_nxt.last  = corr.last;
    pre_nxt.cal   = corr.cal;
    pre_nxt.cx    = corr.cx;
    pre_nxt.cy    = corr.cy;
    pre_nxt.cz    = corr.cz;
    pre_nxt.zero  = (px == '0) && (py == '0);
    pre_nxt.x     = px;
    pre_nxt.y     = py;
    pre_nxt.z     = '0;
    if (px < 0) begin
      if (py >= 0) begin
        pre_nxt.x = py;
        pre_nxt.y = -px;
        pre_nxt.z = DEG_90;
      end else begin
        pre_nxt.x = -py;
        pre_nxt.y = px;
        pre_nxt.z = -DEG_90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= pre_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    pre_r <= pre_nxt;
  end

  // cell chain, one iteration per cell
  cordic_t chain [NST+1];

  always_comb begin
    chain[0] = pre_r;
    chain[0].valid = pre_vld_r;
  end

  for (genvar i = 0; i < NST; i++) begin : g_cell
    mag_cal_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end

  // heading: angle - 90 degrees, wrapped to [0,360), rounded to 1/64 degree
  cordic_t fin;
  logic signed [X_W-1:0] h0, h1, h2;
  logic [16:0] hd0, hd1;
  out_t out_nxt;
  logic out_valid_r;
  out_t out_r;

  assign fin = chain[NST];

  always_comb begin
    h0 = (fin.zero ? '0 : X_W'(fin.z)) - DEG_90H;
    h1 = (h0 < 0) ? h0 + DEG_360 : h0;
    h2 = (h1 >= DEG_360) ? h1 - DEG_360 : h1;
    hd0 = 17'((h2 + X_W'(512)) >>> 10);
    hd1 = (hd0 >= HD_FULL) ? hd0 - HD_FULL : hd0;
    out_nxt.last_out = fin.last;
    if (fin.cal) begin
      out_nxt.corr_x      = fin.cx;
      out_nxt.corr_y      = fin.cy;
      out_nxt.corr_z      = fin.cz;
      out_nxt.heading_deg = hd1[14:0];
      out_nxt.valid_res   = 1'b1;
    end else begin
      // uncalibrated transaction reports zero in every field but last_out
      out_nxt.corr_x      = '0;
      out_nxt.corr_y      = '0;
      out_nxt.corr_z      = '0;
      out_nxt.heading_deg = '0;
      out_nxt.valid_res   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* tb/mag_cal_checker.sv */
// checker for the magnetometer correction unit: predicts each result from the sample and config
// depends on mag_cal_pkg; watches the input and result channels and counts mismatches
`timescale 1ns / 1ps
module mag_cal_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  mag_cal_pkg::in_t  in_data,
  input  logic out_valid,
  input  mag_cal_pkg::out_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [5:0] paddr,
  input  logic [63:0] pwdata,
  input  logic pready,
  output int   mismatches,
  output int   pending,
  output int   results_seen
);
  import mag_cal_pkg::*;

  longint off_x, off_y, off_z;
  logic [53:0] row_q [3];
  logic cal_en;
  out_t expected_q [$];

  localparam longint ONE_DEG = 65536;

  function automatic longint angle_step(int i);
    case (i)
      0: return 2949120;   1: return 1740967; 2: return 919879; 3: return 466945;
      4: return 234379;    5: return 117304;  6: return 58666;  7: return 29335;
      8: return 14668;     9: return 7334;    10: return 3667;  11: return 1833;
      12: return 917;      13: return 458;    14: return 229;   15: return 115;
      16: return 57;       17: return 29;     18: return 14;    19: return 7;
      20: return 4;        21: return 2;      22: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint coef(logic [53:0] r, int col);
    logic signed [17:0] c;
    c = r[col*18 +: 18];
    return longint'(c);
  endfunction

  function automatic longint apply_row(logic [53:0] r, longint a, longint b, longint c);
    longint acc;
    acc = a * coef(r, 0) + b * coef(r, 1) + c * coef(r, 2);
    return clamp24((acc + 8192) >>> 14);
  endfunction

  function automatic longint vector_angle(longint xx, longint yy);
    longint x, y, z, nx, ny;
    x = xx; y = yy; z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; z = 90 * ONE_DEG;
      end else begin
        nx = -y; ny = x; z = -90 * ONE_DEG;
      end
      x = nx; y = ny;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += angle_step(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= angle_step(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint scale_raw(logic signed [15:0] raw);
    return (longint'(raw) * 19661 + 128) >>> 8;
  endfunction

  function automatic out_t correct_sample(in_t s);
    out_t r;
    longint vx, vy, vz, cx, cy, cz, h, hd;
    r = '0;
    r.last_out = s.last_sample;
    if (!cal_en) return r;
    vx = scale_raw(s.mag_x) + off_x;
    vy = scale_raw(s.mag_y) + off_y;
    vz = scale_raw(s.mag_z) + off_z;
    cx = apply_row(row_q[0], vx, vy, vz);
    cy = apply_row(row_q[1], vx, vy, vz);
    cz = apply_row(row_q[2], vx, vy, vz);
    h = vector_angle(cx, -cy) - 90 * ONE_DEG;
    if (h < 0) h += 360 * ONE_DEG;
    if (h >= 360 * ONE_DEG) h -= 360 * ONE_DEG;
    if (h < 0) h = 0;
    hd = (h + 512) >>> 10;
    if (hd >= 360 * 64) hd -= 360 * 64;
    r.corr_x = cx[23:0];
    r.corr_y = cy[23:0];
    r.corr_z = cz[23:0];
    r.heading_deg = hd[14:0];
    r.valid_res = 1'b1;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      off_x <= 0; off_y <= 0; off_z <= 0;
      row_q[0] <= '0; row_q[1] <= '0; row_q[2] <= '0;
      cal_en <= 1'b0;
      mismatches <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      // compare before pushing, so a same-edge input never matches itself
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", out_data);
        end else begin
          out_t e;
          e = expected_q.pop_front();
          if (e !== out_data) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch exp %p got %p", e, out_data);
          end
        end
      end
      if (start && !busy) expected_q.push_back(correct_sample(in_data));
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_OFFSET_X:   off_x <= longint'($signed(pwdata[23:0]));
          REG_OFFSET_Y:   off_y <= longint'($signed(pwdata[23:0]));
          REG_OFFSET_Z:   off_z <= longint'($signed(pwdata[23:0]));
          REG_MATRIX_0:   row_q[0] <= pwdata[53:0];
          REG_MATRIX_1:   row_q[1] <= pwdata[53:0];
          REG_MATRIX_2:   row_q[2] <= pwdata[53:0];
          REG_CALIBRATED: cal_en <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// top of the magnetometer correction testbench: clock, reset, config writes and sample stimulus
// depends on mag_cal_pkg, mag_calibrate_heading_unit and mag_cal_checker
`timescale 1ns / 1ps
module tb_top;
  import mag_cal_pkg::*;

  localparam int STAGES = 16;
  // fixed pipeline depth from the block's header: front end, pre-rotation, cells, output
  localparam int LATENCY = 6 + STAGES;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  int mismatches, pending, results_seen;
  int sent;

  mag_calibrate_heading_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mag_cal_checker #(.CORDIC_STAGES(STAGES)) chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .pending, .results_seen
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // two-phase apb write: setup then access
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // let the pipeline empty before touching registers
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [17:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 18'h1ffff;          // most positive
      1: return 18'h20000;          // most negative
      2: return 18'd16384;          // unity
      default: return 18'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  task automatic load_cal(int flavor);
    logic [63:0] r[3];
    logic [23:0] o[3];
    for (int i = 0; i < 3; i++) begin
      case (flavor)
        0: begin
          r[i] = '0; r[i][i*18 +: 18] = 18'd16384; o[i] = '0;  // identity
        end
        1: begin
          r[i] = {$urandom, $urandom};                          // all bits random
          o[i] = i[0] ? 24'h800000 : 24'h7fffff;
        end
        default: begin
          r[i] = {10'($urandom), rand_coef(), rand_coef(), rand_coef()};
          o[i] = 24'($urandom_range(0, 8000)) - 24'd4000;
          if ($urandom_range(0, 3) == 0) o[i] = 24'($urandom);
        end
      endcase
    end
    reg_write(REG_OFFSET_X, {{40{o[0][23]}}, o[0]} ^ {$urandom, 8'h0, 24'h0});
    reg_write(REG_OFFSET_Y, {{40{o[1][23]}}, o[1]});
    reg_write(REG_OFFSET_Z, {{40{o[2][23]}}, o[2]});
    reg_write(REG_MATRIX_0, r[0]);
    reg_write(REG_MATRIX_1, r[1]);
    reg_write(REG_MATRIX_2, r[2]);
    reg_write(REG_CALIBRATED, {63'($urandom), 1'b1});
  endtask

  // one sample transaction, optionally preceded by an idle burst
  task automatic send(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z,
                      logic lst, bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{mag_x: x, mag_y: y, mag_z: z, last_sample: lst};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // uncalibrated: fields must read zero, last mark still copied
    send(16'h7fff, 16'h8000, 16'h0000, 1'b1, 0);
    send(16'h8000, 16'h7fff, 16'hffff, 1'b0, 0);
    start <= 1'b0;
    drain();

    // identity matrix, zero offset: extremes, zero vector and the four quadrants
    load_cal(0);
    send(16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
    send(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 0);
    send(16'h8000, 16'h8000, 16'h8000, 1'b0, 0);
    send(16'd1000, 16'd0, 16'd5, 1'b0, 0);
    send(-16'sd1000, 16'd0, 16'd5, 1'b1, 0);
    send(16'd0, 16'd1000, -16'sd5, 1'b0, 0);
    send(16'd0, -16'sd1000, 16'd0, 1'b0, 0);
    send(-16'sd700, 16'd700, 16'd1, 1'b0, 0);
    send(-16'sd700, -16'sd700, 16'd1, 1'b1, 0);
    send(16'd700, -16'sd700, 16'd1, 1'b0, 0);
    send(16'd1, -16'sd1, 16'd0, 1'b0, 0);
    start <= 1'b0;
    drain();

    // saturating corners: extreme offsets and fully random coefficients
    load_cal(1);
    send(16'h7fff, 16'h8000, 16'h7fff, 1'b1, 0);
    send(16'h8000, 16'h7fff, 16'h8000, 1'b0, 0);
    send(16'h5555, 16'haaaa, 16'h5555, 1'b1, 0);
    start <= 1'b0;
    drain();

    // random phases under several calibrations
    for (int ph = 0; ph < 6; ph++) begin
      load_cal(2);
      for (int k = 0; k < 85; k++) begin
        send(rand_raw(), rand_raw(), rand_raw(), 1'($urandom), ph < 5);
        // hold off once until the pipe is empty
        if (ph == 2 && k == 40) begin
          start <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
      drain();
    end

    // calibration cleared again
    reg_write(REG_CALIBRATED, 64'd0);
    send(rand_raw(), rand_raw(), rand_raw(), 1'b1, 0);
    start <= 1'b0;
    drain();

    $display("sent %0d samples over uncalibrated, identity, saturating and random calibrations;",
             sent);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mag_cal_pkg.sv
design/mag_cal_front.sv
design/mag_cal_cordic_cell.sv
design/mag_calibrate_heading_unit.sv
tb/mag_cal_checker.sv
tb/tb_top.sv
